// ===== sv/time_ordered_event_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the time-ordered event queue
// Shorthand for clocked implication checks with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEOQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TEOQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/teoq_pkg.sv =====
// ---------------------------------------------------------------------------
// teoq_pkg
// Shared constants, codes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package teoq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int TIME_BITS     = 48;
  localparam int ID_BITS       = 16;
  localparam int DELAY_BITS    = 32;
  localparam int OUT_TIME_BITS = 48;

  typedef enum logic {
    ACT_SCHEDULE = 1'b0,
    ACT_POP      = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_SCHEDULED = 2'd0,
    ST_POPPED    = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the incoming transaction and its due time
    logic init_scan;  // point the scan at the tail of the queue
    logic rd_scan;    // read the entry under the scan pointer
    logic rd_head;    // read the head entry
    logic shift;      // move the scanned entry one slot toward the tail
    logic put;        // write the new entry at the write pointer
    logic set_full;   // record a dropped event
    logic set_empty;  // record a pop on an empty queue
    logic pop;        // retire the head entry
    logic load_out;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic is_full;
    logic is_empty;
    logic t_lt;       // new time earlier than the scanned entry
    logic last;       // scanned entry is the head
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/teoq_if.sv =====
// ---------------------------------------------------------------------------
// teoq request and response channels
// Valid/ready channels carrying queue commands and their results.
// ---------------------------------------------------------------------------
interface teoq_req_if;
  logic                                valid;
  logic                                ready;
  teoq_pkg::action_t                   action;
  logic [teoq_pkg::ID_BITS-1:0]        event_id;
  logic [teoq_pkg::DELAY_BITS-1:0]     delay;

  modport source (output valid, output action, output event_id, output delay,
                  input ready);
  modport sink   (input valid, input action, input event_id, input delay,
                  output ready);
endinterface

interface teoq_rsp_if;
  logic                                valid;
  logic                                ready;
  teoq_pkg::status_t                   status;
  logic [teoq_pkg::ID_BITS-1:0]        popped_id;
  logic [teoq_pkg::OUT_TIME_BITS-1:0]  event_time;

  modport source (output valid, output status, output popped_id,
                  output event_time, input ready);
  modport sink   (input valid, input status, input popped_id,
                  input event_time, output ready);
endinterface

// ===== sv/teoq_ram.sv =====
// ---------------------------------------------------------------------------
// teoq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module teoq_ram #(
  parameter int WIDTH = teoq_pkg::TIME_BITS + teoq_pkg::ID_BITS,
  parameter int DEPTH = teoq_pkg::QUEUE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/teoq_ctrl.sv =====
// ---------------------------------------------------------------------------
// teoq_ctrl
// Sequencer for schedule and pop transactions.
// ---------------------------------------------------------------------------
module teoq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  teoq_pkg::ctrl_sts_t   sts,
  output teoq_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CMP,
    S_PUT,
    S_POP_RD,
    S_POP,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.is_pop && sts.is_empty) begin
          cmd.set_empty = 1'b1;
          state_next    = S_OUT;
        end else if (sts.is_pop) begin
          state_next = S_POP_RD;
        end else if (sts.is_full) begin
          cmd.set_full = 1'b1;
          state_next   = S_OUT;
        end else if (sts.is_empty) begin
          cmd.init_scan = 1'b1;
          state_next    = S_PUT;
        end else begin
          cmd.init_scan = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        if (sts.t_lt) begin
          cmd.shift  = 1'b1;
          state_next = sts.last ? S_PUT : S_READ;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_OUT;
      end
      S_POP_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_POP;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/teoq_datapath.sv =====
// ---------------------------------------------------------------------------
// teoq_datapath
// Circular sorted entry store, scan pointers, time arithmetic and output
// register.
// ---------------------------------------------------------------------------
`include "time_ordered_event_queue_macros.svh"

module teoq_datapath #(
  parameter int QUEUE_DEPTH = teoq_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS   = teoq_pkg::TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  teoq_pkg::ctrl_cmd_t                 cmd,
  output teoq_pkg::ctrl_sts_t                 sts,
  input  teoq_pkg::action_t                   in_action,
  input  logic [teoq_pkg::ID_BITS-1:0]        in_event_id,
  input  logic [teoq_pkg::DELAY_BITS-1:0]     in_delay,
  input  logic                                out_ready,
  output logic                                out_valid,
  output teoq_pkg::status_t                   out_status,
  output logic [teoq_pkg::ID_BITS-1:0]        out_popped_id,
  output logic [teoq_pkg::OUT_TIME_BITS-1:0]  out_event_time
);

  localparam int ID_BITS  = teoq_pkg::ID_BITS;
  localparam int PW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD     = TIME_BITS + ID_BITS;
  localparam int SUM_BITS =
    ((TIME_BITS > teoq_pkg::DELAY_BITS) ? TIME_BITS : teoq_pkg::DELAY_BITS) + 1;
  localparam int EXT_BITS =
    (TIME_BITS > teoq_pkg::OUT_TIME_BITS) ? TIME_BITS : teoq_pkg::OUT_TIME_BITS;
  localparam logic [PW-1:0]        LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST_PTR : p - PW'(1);
  endfunction

  // Control state
  logic [TIME_BITS-1:0] current_time;
  logic [PW-1:0]        head;
  logic [PW-1:0]        tail;
  logic [CW-1:0]        count;

  // Working registers
  teoq_pkg::action_t    act;
  logic [ID_BITS-1:0]   new_id;
  logic [TIME_BITS-1:0] new_time;
  logic [PW-1:0]        rd_ptr;
  logic [PW-1:0]        wr_ptr;
  logic [CW-1:0]        remain;
  teoq_pkg::status_t    res_status;
  logic [ID_BITS-1:0]   res_id;
  logic [TIME_BITS-1:0] res_time;

  // Due time with saturation
  logic [SUM_BITS-1:0]  sum;
  logic [TIME_BITS-1:0] due;
  logic [EXT_BITS-1:0]  res_ext;

  assign sum     = SUM_BITS'(current_time) + SUM_BITS'(in_delay);
  assign due     = (sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
  assign res_ext = EXT_BITS'(res_time);

  // Entry store
  logic            ram_we;
  logic [PW-1:0]   ram_waddr;
  logic [WORD-1:0] ram_wdata;
  logic            ram_re;
  logic [PW-1:0]   ram_raddr;
  logic [WORD-1:0] ram_q;
  logic [TIME_BITS-1:0] q_time;
  logic [ID_BITS-1:0]   q_id;

  assign ram_we    = cmd.shift | cmd.put;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = cmd.put ? {new_time, new_id} : ram_q;
  assign ram_re    = cmd.rd_scan | cmd.rd_head;
  assign ram_raddr = cmd.rd_head ? head : rd_ptr;
  assign q_time    = ram_q[WORD-1:ID_BITS];
  assign q_id      = ram_q[ID_BITS-1:0];

  teoq_ram #(
    .WIDTH (WORD),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  always_comb begin
    sts.is_pop   = (act == teoq_pkg::ACT_POP);
    sts.is_full  = (count == CW'(QUEUE_DEPTH));
    sts.is_empty = (count == '0);
    sts.t_lt     = (new_time < q_time);
    sts.last     = (remain == CW'(1));
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.put) begin
        tail  <= ptr_inc(tail);
        count <= count + CW'(1);
      end
      if (cmd.pop) begin
        head         <= ptr_inc(head);
        count        <= count - CW'(1);
        current_time <= q_time;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act      <= in_action;
      new_id   <= in_event_id;
      new_time <= due;
    end
    if (cmd.init_scan) begin
      rd_ptr <= ptr_dec(tail);
      wr_ptr <= tail;
      remain <= count;
    end
    if (cmd.shift) begin
      wr_ptr <= rd_ptr;
      rd_ptr <= ptr_dec(rd_ptr);
      remain <= remain - CW'(1);
    end
    if (cmd.put) begin
      res_status <= teoq_pkg::ST_SCHEDULED;
      res_id     <= '0;
      res_time   <= new_time;
    end
    if (cmd.set_full) begin
      res_status <= teoq_pkg::ST_FULL;
      res_id     <= '0;
      res_time   <= new_time;
    end
    if (cmd.set_empty) begin
      res_status <= teoq_pkg::ST_EMPTY;
      res_id     <= '0;
      res_time   <= '0;
    end
    if (cmd.pop) begin
      res_status <= teoq_pkg::ST_POPPED;
      res_id     <= q_id;
      res_time   <= q_time;
    end
    if (cmd.load_out) begin
      out_status     <= res_status;
      out_popped_id  <= res_id;
      out_event_time <= res_ext[teoq_pkg::OUT_TIME_BITS-1:0];
    end
  end

  `TEOQ_ASSERT_SAME(a_put_has_room, clk, rst, cmd.put, count < CW'(QUEUE_DEPTH), "insert into full queue")
  `TEOQ_ASSERT_SAME(a_pop_has_entry, clk, rst, cmd.pop, count != '0, "pop from empty queue")
  `TEOQ_ASSERT_SAME(a_shift_later, clk, rst, cmd.shift, new_time < q_time, "moved an entry not due later")
  `TEOQ_ASSERT_NEXT(a_time_forward, clk, rst, cmd.pop, current_time >= $past(current_time), "time moved back")

endmodule

// ===== sv/time_ordered_event_queue.sv =====
// ---------------------------------------------------------------------------
// time_ordered_event_queue: one transaction at a time. Full/empty results go from dispatch to
// output; a pop reads and retires the head; a schedule reads each queued event from the tail,
// shifts it while due later, then writes the new one; next request after the output load.
// Synchronous reset empties the queue and zeroes current time; no RAM clearing pass.
// ---------------------------------------------------------------------------
module time_ordered_event_queue #(
  parameter int QUEUE_DEPTH = teoq_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS   = teoq_pkg::TIME_BITS
) (
  input logic       clk,
  input logic       rst,
  teoq_req_if.sink  req,
  teoq_rsp_if.source rsp
);

  // The queue is a circular buffer held sorted by due time, head holding the
  // earliest event. A pop reads the head and advances it. A schedule walks
  // from the tail toward the head: each entry due strictly later than the new
  // event moves one slot toward the tail, and the new event drops into the
  // first hole behind an entry that is not later. Equal times therefore keep
  // arrival order.
  //
  // The result of a transaction sits in an output register, so the next
  // request is taken while a finished result still waits for the sink.

  teoq_pkg::ctrl_cmd_t cmd;
  teoq_pkg::ctrl_sts_t sts;

  // Sequence each transaction: dispatch, scan or head read, then hand off.
  teoq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the entries, the time base and the result registers.
  teoq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (req.action),
    .in_event_id    (req.event_id),
    .in_delay       (req.delay),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_status     (rsp.status),
    .out_popped_id  (rsp.popped_id),
    .out_event_time (rsp.event_time)
  );

endmodule
